/* sv/cleb_pkg.sv */
package cleb_pkg;

	localparam int LINE_SIZE_DEF = 64;
	localparam int OP_W          = 4;
	localparam int BYTE_W        = 8;
	localparam int POS_W         = 6;

	// request opcodes; 9..15 carry no meaning and are ignored
	typedef enum logic [OP_W-1:0] {
		OP_INSERT    = 4'd0,
		OP_BACKSPACE = 4'd1,
		OP_DELETE    = 4'd2,
		OP_LEFT      = 4'd3,
		OP_RIGHT     = 4'd4,
		OP_HOME      = 4'd5,
		OP_END       = 4'd6,
		OP_CLEAR     = 4'd7,
		OP_READ      = 4'd8
	} op_t;

	// edit applied to the cell row
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_WIPE
	} cell_op_t;

	typedef struct packed {
		logic ovf;   // insert filled the line, line wiped
		logic none;  // refused or no change
		logic rd;    // read request
	} edit_flags_t;

endpackage

/* sv/cleb_ctrl.sv */
// Decodes one request against the current length and cursor.
module cleb_ctrl import cleb_pkg::*; #(
	parameter  int LINE_SIZE = LINE_SIZE_DEF,
	localparam int LW        = $clog2(LINE_SIZE)
) (
	input  logic [OP_W-1:0] opcode,
	input  logic [LW-1:0]   len,
	input  logic [LW-1:0]   cursor,
	output logic [LW-1:0]   nxt_len,
	output logic [LW-1:0]   nxt_cursor,
	output cell_op_t        cell_op,
	output logic [LW-1:0]   cell_pos,
	output edit_flags_t     flags
);

	localparam logic [LW-1:0] FULL = LW'(LINE_SIZE - 1);

	always_comb begin
		nxt_len    = len;
		nxt_cursor = cursor;
		cell_op    = CELL_HOLD;
		cell_pos   = cursor;
		flags      = '0;
		unique case (opcode)
			OP_INSERT: begin
				if (len >= FULL) begin
					flags.none = 1'b1;
				end else if (len + 1'b1 == FULL) begin
					cell_op    = CELL_WIPE;
					nxt_len    = '0;
					nxt_cursor = '0;
					flags.ovf  = 1'b1;
				end else begin
					cell_op    = CELL_INSERT;
					nxt_len    = len + 1'b1;
					nxt_cursor = cursor + 1'b1;
				end
			end
			OP_BACKSPACE: begin
				if (cursor == '0) begin
					flags.none = 1'b1;
				end else begin
					cell_op    = CELL_REMOVE;
					cell_pos   = cursor - 1'b1;
					nxt_len    = len - 1'b1;
					nxt_cursor = cursor - 1'b1;
				end
			end
			OP_DELETE: begin
				if (cursor >= len) begin
					flags.none = 1'b1;
				end else begin
					cell_op = CELL_REMOVE;
					nxt_len = len - 1'b1;
				end
			end
			OP_LEFT: begin
				if (cursor == '0) flags.none = 1'b1;
				else              nxt_cursor = cursor - 1'b1;
			end
			OP_RIGHT: begin
				if (cursor >= len) flags.none = 1'b1;
				else               nxt_cursor = cursor + 1'b1;
			end
			OP_HOME: begin
				if (cursor == '0) flags.none = 1'b1;
				nxt_cursor = '0;
			end
			OP_END: begin
				if (cursor == len) flags.none = 1'b1;
				nxt_cursor = len;
			end
			OP_CLEAR: begin
				if (len == '0) flags.none = 1'b1;
				cell_op    = CELL_WIPE;
				nxt_len    = '0;
				nxt_cursor = '0;
			end
			OP_READ: begin
				flags.none = 1'b1;
				flags.rd   = 1'b1;
			end
			default: begin
				flags.none = 1'b1;
			end
		endcase
	end

endmodule

/* sv/cleb_cells.sv */
// Row of byte cells; each cell loads from itself, a neighbor, the new byte or zero.
module cleb_cells import cleb_pkg::*; #(
	parameter  int LINE_SIZE = LINE_SIZE_DEF,
	localparam int LW        = $clog2(LINE_SIZE)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  cell_op_t          cell_op,
	input  logic [LW-1:0]     pos,
	input  logic [BYTE_W-1:0] char_code,
	input  logic [LW-1:0]     rd_idx,
	output logic [BYTE_W-1:0] rd_byte
);

	logic [BYTE_W-1:0] cell_q [LINE_SIZE];

	for (genvar g = 0; g < LINE_SIZE; g++) begin : g_cell
		logic [BYTE_W-1:0] prev_byte;
		logic [BYTE_W-1:0] next_byte;
		logic [BYTE_W-1:0] cell_d;

		if (g == 0) begin : g_first
			assign prev_byte = '0;
		end else begin : g_prev
			assign prev_byte = cell_q[g-1];
		end

		if (g == LINE_SIZE - 1) begin : g_last
			assign next_byte = '0;
		end else begin : g_next
			assign next_byte = cell_q[g+1];
		end

		always_comb begin
			unique case (cell_op)
				CELL_HOLD:   cell_d = cell_q[g];
				CELL_INSERT: begin
					if (LW'(g) > pos)       cell_d = prev_byte;
					else if (LW'(g) == pos) cell_d = char_code;
					else                    cell_d = cell_q[g];
				end
				CELL_REMOVE: cell_d = (LW'(g) >= pos) ? next_byte : cell_q[g];
				CELL_WIPE:   cell_d = '0;
				default:     cell_d = cell_q[g];
			endcase
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cell_q[g] <= '0;
			end else if (en) begin
				cell_q[g] <= cell_d;
			end
		end
	end

	assign rd_byte = cell_q[rd_idx];

endmodule

/* sv/cursor_line_edit_buffer.sv */
// Line edit buffer: holds one terminal input line of up to LINE_SIZE-2 bytes with its
// length and an edit cursor, and applies one edit request per item (insert, backspace,
// delete, left, right, home, end, clear, read). Each request returns the new length and
// cursor, the byte read (read only, zero past the line end), an overflow flag when an
// insert brings the line to LINE_SIZE-1 bytes (the line is then wiped), and a no-effect
// flag for refused or idle requests. Timing: a request is taken into an input register and
// its result is registered in the output register once that register is free or being
// drained; one request per cycle is sustained while results are taken, because every edit
// is one parallel shift of the cell row, each cell loading from its neighbor. While a
// result waits in the output register, one more request is taken into the input register
// and the request side then stalls until the result is taken. Reset clears the line,
// length and cursor at once; no clearing pass is needed.
module cursor_line_edit_buffer import cleb_pkg::*; #(
	parameter int LINE_SIZE = LINE_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   opcode,
	input  logic [BYTE_W-1:0] char_code,
	input  logic [POS_W-1:0]  read_index,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [POS_W-1:0]  line_length,
	output logic [POS_W-1:0]  cursor_pos,
	output logic [BYTE_W-1:0] read_byte,
	output logic              overflow_cleared,
	output logic              no_effect
);

	localparam int LW = $clog2(LINE_SIZE);
	// common width for comparing the read index against the length
	localparam int CW = (LW > POS_W) ? LW : POS_W;
	localparam logic [LW-1:0] FULL = LW'(LINE_SIZE - 1);

	// input register
	logic              valid_s1;
	logic [OP_W-1:0]   opcode_s1;
	logic [BYTE_W-1:0] char_code_s1;
	logic [POS_W-1:0]  read_index_s1;

	// line state
	logic [LW-1:0] len_q;
	logic [LW-1:0] cursor_q;

	// result register
	logic              out_valid_q;
	logic [POS_W-1:0]  line_length_q;
	logic [POS_W-1:0]  cursor_pos_q;
	logic [BYTE_W-1:0] read_byte_q;
	logic              overflow_q;
	logic              no_effect_q;

	// decode outputs
	logic [LW-1:0]     nxt_len;
	logic [LW-1:0]     nxt_cursor;
	cell_op_t          cell_op;
	logic [LW-1:0]     cell_pos;
	edit_flags_t       flags;
	logic [BYTE_W-1:0] cell_rd;
	logic [BYTE_W-1:0] read_byte_d;
	logic              rd_hit;
	logic              adv;

	// the held request executes once the result register is free or being drained
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1     <= opcode;
			char_code_s1  <= char_code;
			read_index_s1 <= read_index;
		end
	end

	cleb_ctrl #(
		.LINE_SIZE (LINE_SIZE)
	) u_ctrl (
		.opcode     (opcode_s1),
		.len        (len_q),
		.cursor     (cursor_q),
		.nxt_len    (nxt_len),
		.nxt_cursor (nxt_cursor),
		.cell_op    (cell_op),
		.cell_pos   (cell_pos),
		.flags      (flags)
	);

	// cells only change on an executed request
	cleb_cells #(
		.LINE_SIZE (LINE_SIZE)
	) u_cells (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.cell_op   (cell_op),
		.pos       (cell_pos),
		.char_code (char_code_s1),
		.rd_idx    (LW'(read_index_s1)),
		.rd_byte   (cell_rd)
	);

	// reads past the line end return zero; index is in range whenever it hits
	assign rd_hit      = CW'(read_index_s1) < CW'(len_q);
	assign read_byte_d = (flags.rd && rd_hit) ? cell_rd : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			cursor_q <= '0;
		end else if (adv) begin
			len_q    <= nxt_len;
			cursor_q <= nxt_cursor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			line_length_q <= POS_W'(nxt_len);
			cursor_pos_q  <= POS_W'(nxt_cursor);
			read_byte_q   <= read_byte_d;
			overflow_q    <= flags.ovf;
			no_effect_q   <= flags.none;
		end
	end

	assign out_valid        = out_valid_q;
	assign line_length      = line_length_q;
	assign cursor_pos       = cursor_pos_q;
	assign read_byte        = read_byte_q;
	assign overflow_cleared = overflow_q;
	assign no_effect        = no_effect_q;

	// cursor never passes the line end
	a_cursor_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= len_q)
		else $error("cursor beyond line length");

	// an insert that fills the line wipes it, so the stored length stays short
	a_len_short: assert property (@(posedge clk) disable iff (!arst_n)
		len_q < FULL)
		else $error("line length reached overflow level");

	// an executed request always leaves a result behind
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("executed request left no result");

	// overflow reports an empty line and is never a refused request
	a_ovf_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && overflow_q |-> line_length_q == '0 && cursor_pos_q == '0 && !no_effect_q)
		else $error("overflow result inconsistent");

	// a nonzero read byte only comes from a read, which never changes state
	a_read_noeffect: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && read_byte_q != '0 |-> no_effect_q)
		else $error("read byte on a state-changing request");

endmodule

/* bench/tb.sv */
module tb import cleb_pkg::*;;

	localparam int LINE_CELLS     = LINE_SIZE_DEF;
	localparam int RX_HOLD_CYCLES = 120;   // long receiver hold-off, fills the block
	localparam int STALL_LIMIT    = 2000;  // cycles with no handshake before giving up
	localparam int DRAIN_CYCLES   = 8;     // extra wait once no result is owed
	localparam int SEGMENTS       = 12;
	localparam int SEG_ITEMS      = 80;
	localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_READ + 4'd1;
	localparam logic [OP_W-1:0] OP_LAST_UNUSED  = {OP_W{1'b1}};

	// request mixes for the random part
	typedef enum {
		MIX_GROW,   // mostly inserts, drives the line to the overflow wipe
		MIX_EDIT,   // moves, removals and reads on a short line
		MIX_BROAD   // everything, clears and unused opcodes included
	} mix_t;

	typedef struct {
		logic [POS_W-1:0]  len;
		logic [POS_W-1:0]  cur;
		logic [BYTE_W-1:0] rbyte;
		logic              ovf;
		logic              none;
	} edit_result_t;

	// Line model plus the queue of results still owed by the block.
	class edit_result_board;
		logic [BYTE_W-1:0] cells[LINE_CELLS];
		int                line_len;
		int                cursor;
		edit_result_t      owed[$];
		int                errors;
		int                requests;
		int                checked;
		int                overflows;
		int                longest;
		int                reads_inside;

		function new();
			wipe();
			errors       = 0;
			requests     = 0;
			checked      = 0;
			overflows    = 0;
			longest      = 0;
			reads_inside = 0;
		endfunction

		function void wipe();
			foreach (cells[i])
				cells[i] = '0;
			line_len = 0;
			cursor   = 0;
		endfunction

		// drop cell p and pull the tail left; the freed top cell goes back to zero
		function void remove_cell(int p);
			int i;
			for (i = p; i + 1 < line_len; i++)
				cells[i] = cells[i + 1];
			cells[line_len - 1] = '0;
			line_len--;
		endfunction

		function void note_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] ch,
				logic [POS_W-1:0] idx);
			edit_result_t res;
			int           i;
			res.len   = '0;
			res.cur   = '0;
			res.rbyte = '0;
			res.ovf   = 1'b0;
			res.none  = 1'b0;
			requests++;
			case (op)
				OP_INSERT: begin
					if (line_len >= LINE_CELLS - 1) begin
						res.none = 1'b1;
					end else begin
						for (i = line_len; i > cursor; i--)
							cells[i] = cells[i - 1];
						cells[cursor] = ch;
						line_len++;
						cursor++;
						if (line_len > longest)
							longest = line_len;
						// reaching LINE_SIZE-1 bytes wipes the whole line
						if (line_len >= LINE_CELLS - 1) begin
							wipe();
							res.ovf = 1'b1;
							overflows++;
						end
					end
				end
				OP_BACKSPACE: begin
					if (cursor == 0) begin
						res.none = 1'b1;
					end else begin
						remove_cell(cursor - 1);
						cursor--;
					end
				end
				OP_DELETE: begin
					if (cursor >= line_len)
						res.none = 1'b1;
					else
						remove_cell(cursor);
				end
				OP_LEFT: begin
					if (cursor == 0)
						res.none = 1'b1;
					else
						cursor--;
				end
				OP_RIGHT: begin
					if (cursor >= line_len)
						res.none = 1'b1;
					else
						cursor++;
				end
				OP_HOME: begin
					if (cursor == 0)
						res.none = 1'b1;
					cursor = 0;
				end
				OP_END: begin
					if (cursor == line_len)
						res.none = 1'b1;
					cursor = line_len;
				end
				OP_CLEAR: begin
					if (line_len == 0)
						res.none = 1'b1;
					wipe();
				end
				OP_READ: begin
					if (idx < line_len) begin
						res.rbyte = cells[idx];
						reads_inside++;
					end
					res.none = 1'b1;
				end
				default: begin
					res.none = 1'b1;
				end
			endcase
			res.len = line_len[POS_W-1:0];
			res.cur = cursor[POS_W-1:0];
			owed.push_back(res);
		endfunction

		function void compare_field(string field, logic [BYTE_W-1:0] want,
				logic [BYTE_W-1:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(edit_result_t got);
			edit_result_t want;
			if (owed.size() == 0) begin
				$error("result with no request pending: length %0d cursor %0d",
					got.len, got.cur);
				errors++;
				return;
			end
			want = owed.pop_front();
			checked++;
			compare_field("line_length", want.len, got.len);
			compare_field("cursor_pos", want.cur, got.cur);
			compare_field("read_byte", want.rbyte, got.rbyte);
			compare_field("overflow_cleared", want.ovf, got.ovf);
			compare_field("no_effect", want.none, got.none);
		endfunction
	endclass

	logic              clk              = 1'b0;
	logic              arst_n           = 1'b0;
	logic              in_valid         = 1'b0;
	logic              in_ready;
	logic [OP_W-1:0]   opcode           = '0;
	logic [BYTE_W-1:0] char_code        = '0;
	logic [POS_W-1:0]  read_index       = '0;
	logic              out_valid;
	logic              out_ready        = 1'b0;
	logic [POS_W-1:0]  line_length;
	logic [POS_W-1:0]  cursor_pos;
	logic [BYTE_W-1:0] read_byte;
	logic              overflow_cleared;
	logic              no_effect;

	edit_result_board board = new();

	bit idle_on        = 1'b1;  // random gaps and stalls enabled
	bit rx_hold_req    = 1'b0;  // asks the result sink for one long hold-off
	int pressure_items = 0;     // requests still to send back to back
	int idle_cycles    = 0;

	always #6 clk = ~clk;

	cursor_line_edit_buffer i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.opcode           (opcode),
		.char_code        (char_code),
		.read_index       (read_index),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.line_length      (line_length),
		.cursor_pos       (cursor_pos),
		.read_byte        (read_byte),
		.overflow_cleared (overflow_cleared),
		.no_effect        (no_effect)
	);

	// Monitor: note requests, check results, and watch for a hang.
	// Requests are noted first so a result of the same edge still finds its entry.
	always @(posedge clk) begin : monitor
		edit_result_t got;
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_request(opcode, char_code, read_index);
			if (out_valid && out_ready) begin
				got.len   = line_length;
				got.cur   = cursor_pos;
				got.rbyte = read_byte;
				got.ovf   = overflow_cleared;
				got.none  = no_effect;
				board.check_result(got);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Result sink: mostly ready, short and rare long stalls, plus the long hold-off
	// that lets the block back up into its request side.
	initial begin : result_sink
		int stall_left;
		int r;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				stall_left  = RX_HOLD_CYCLES;
				rx_hold_req = 1'b0;
			end else if (stall_left == 0 && idle_on) begin
				r = $urandom_range(0, 99);
				if (r < 15)
					stall_left = $urandom_range(1, 3);
				else if (r < 18)
					stall_left = $urandom_range(10, 30);
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Ends on a falling edge; lowers valid only when a gap is taken.
	task automatic wait_gap();
		int gap;
		int r;
		gap = 0;
		if (pressure_items > 0) begin
			pressure_items--;
		end else if (idle_on) begin
			r = $urandom_range(0, 99);
			if (r >= 90)
				gap = $urandom_range(8, 30);
			else if (r >= 60)
				gap = $urandom_range(1, 3);
		end
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Drive one request and hold it until the block takes it.
	task automatic present_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] ch,
			logic [POS_W-1:0] idx);
		in_valid   <= 1'b1;
		opcode     <= op;
		char_code  <= ch;
		read_index <= idx;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic send_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] ch,
			logic [POS_W-1:0] idx);
		wait_gap();
		present_request(op, ch, idx);
	endtask

	// Called on a falling edge, after the monitor has updated the line model.
	task automatic pick_request(input mix_t mix, output logic [OP_W-1:0] op,
			output logic [BYTE_W-1:0] ch, output logic [POS_W-1:0] idx);
		int r;
		int kind;  // 0 insert, 1 removal, 2 move, 3 read, 4 clear, 5 unused
		r = $urandom_range(0, 99);
		case (mix)
			MIX_GROW:  kind = (r < 78) ? 0 : (r < 86) ? 2 : (r < 96) ? 3 : 1;
			MIX_EDIT:  kind = (r < 30) ? 0 : (r < 50) ? 1 : (r < 75) ? 2 :
			                  (r < 95) ? 3 : (r < 98) ? 4 : 5;
			default:   kind = (r < 35) ? 0 : (r < 50) ? 1 : (r < 70) ? 2 :
			                  (r < 88) ? 3 : (r < 92) ? 4 : 5;
		endcase
		case (kind)
			0: op = OP_INSERT;
			1: op = $urandom_range(0, 1) ? OP_BACKSPACE : OP_DELETE;
			2: begin
				case ($urandom_range(0, 3))
					0: op = OP_LEFT;
					1: op = OP_RIGHT;
					2: op = OP_HOME;
					default: op = OP_END;
				endcase
			end
			3: op = OP_READ;
			4: op = OP_CLEAR;
			default: op = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
		endcase
		ch = 8'($urandom_range(0, 255));
		// mostly positions inside the line or just past its end
		if (board.line_len > 0 && $urandom_range(0, 3) != 0)
			idx = 6'($urandom_range(0, board.line_len));
		else
			idx = 6'($urandom_range(0, 63));
	endtask

	initial begin : stimulus
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] ch;
		logic [POS_W-1:0]  idx;
		mix_t              mix;
		int                seg;
		int                n;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// directed: every no-op corner on the empty line first
		send_request(OP_HOME,      8'h00, 6'd0);
		send_request(OP_BACKSPACE, 8'hff, 6'd0);
		send_request(OP_DELETE,    8'h00, 6'd0);
		send_request(OP_LEFT,      8'h00, 6'd0);
		send_request(OP_RIGHT,     8'h00, 6'd0);
		send_request(OP_END,       8'h00, 6'd0);
		send_request(OP_CLEAR,     8'h00, 6'd0);
		send_request(OP_READ,      8'h00, 6'd0);
		// byte extremes, then an insert in the middle of the line
		send_request(OP_INSERT,    8'h00, 6'd0);
		send_request(OP_INSERT,    8'hff, 6'd63);
		send_request(OP_INSERT,    8'ha5, 6'd0);
		send_request(OP_LEFT,      8'h00, 6'd0);
		send_request(OP_INSERT,    8'h5a, 6'd0);
		send_request(OP_HOME,      8'h00, 6'd0);
		send_request(OP_DELETE,    8'h00, 6'd0);
		send_request(OP_END,       8'h00, 6'd0);
		send_request(OP_BACKSPACE, 8'h00, 6'd0);
		send_request(OP_READ,      8'h00, 6'd0);
		send_request(OP_READ,      8'h00, 6'd1);
		send_request(OP_READ,      8'hff, 6'd63);
		send_request(OP_FIRST_UNUSED, 8'h00, 6'd0);
		send_request(OP_LAST_UNUSED,  8'hff, 6'd63);
		send_request(OP_CLEAR,     8'h00, 6'd0);
		send_request(OP_READ,      8'h00, 6'd0);

		// random segments; grow segments reach the overflow wipe
		for (seg = 0; seg < SEGMENTS; seg++) begin
			case ($urandom_range(0, 2))
				0: mix = MIX_GROW;
				1: mix = MIX_EDIT;
				default: mix = MIX_BROAD;
			endcase
			if (seg == 1 || seg == 6)
				mix = MIX_GROW;
			// one segment in four, and always the sixth, runs with no idling at all
			idle_on = !(seg == 5 || $urandom_range(0, 3) == 0);
			if (seg == 3 || seg == 8) begin
				rx_hold_req    = 1'b1;
				pressure_items = 48;
			end
			for (n = 0; n < SEG_ITEMS; n++) begin
				wait_gap();
				pick_request(mix, op, ch, idx);
				present_request(op, ch, idx);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		idle_on = 1'b0;
		while (board.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.owed.size() != 0) begin
			$error("%0d results never arrived", board.owed.size());
			board.errors++;
		end
		$display("Covered %0d edit requests, %0d results compared, %0d overflow wipes.",
			board.requests, board.checked, board.overflows);
		$display("Longest line %0d bytes, %0d reads landed inside the line.",
			board.longest, board.reads_inside);
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
